// File: sv/capture_frequency_meter_assert.svh
// assertion macros for the capture frequency meter
`ifndef CAPTURE_FREQUENCY_METER_ASSERT_SVH
`define CAPTURE_FREQUENCY_METER_ASSERT_SVH

// same-cycle implication, clocked on clock, off during reset
`define CFM_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("capture_frequency_meter assertion failed");

// next-cycle implication, clocked on clock, off during reset
`define CFM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("capture_frequency_meter assertion failed");

`endif

// File: sv/cfm_pkg.sv
// shared types and constants for the capture frequency meter
package cfm_pkg;
   localparam int RING_DEPTH_DEFAULT = 8;
   localparam int PERIOD_W = 17;
   localparam int FREQ_W = 48;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMER_PERIOD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMER_CLOCK_HZ = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_FREQ_Q16 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_MS = 3'd4;

   localparam logic [1:0] STATUS_IDENT = 2'd0;
   localparam logic [1:0] STATUS_OK = 2'd1;
   localparam logic [1:0] STATUS_FAULT = 2'd2;
   localparam logic [1:0] STATUS_DISABLED = 2'd3;

   localparam logic [0:0] OP_CAPTURE = 1'b0;
   localparam logic [0:0] OP_EVALUATE = 1'b1;

   localparam logic [15:0] TIMER_PERIOD_RESET = 16'hFFFF;
   localparam logic [31:0] TIMEOUT_RESET = 32'd2000;
   localparam logic [3:0] SAMPLES_MAX = 4'd15;

   typedef struct packed {
      logic        enable;
      logic [15:0] timer_period;
      logic [31:0] clock_hz;
      logic [31:0] min_freq;
      logic [31:0] timeout;
   } cfg_type;

   typedef struct packed {
      logic                is_eval;
      logic                store;
      logic [PERIOD_W-1:0] delta;
      logic [31:0]         now_ms;
   } cmd_type;
endpackage

// File: sv/cfm_ram.sv
// generic single-write, registered-read ram
module cfm_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: sv/cfm_front.sv
// front end: takes words, works out capture deltas, classifies commands
module cfm_front (
   input  logic             clock,
   input  logic             reset,
   input  cfm_pkg::cfg_type cfg,
   input  logic             push,
   input  logic [0:0]       req_opcode,
   input  logic [15:0]      req_capture_value,
   input  logic [31:0]      req_now_ms,
   input  logic             q_full,
   output logic             q_push,
   output cfm_pkg::cmd_type q_cmd
);
   logic [15:0] last_ff;
   logic [15:0] last_in;
   logic [16:0] wrap_delta;
   logic [15:0] fwd_delta;
   logic [16:0] delta;
   logic        is_capture;

   assign q_push = push && !q_full;
   assign is_capture = (req_opcode == cfm_pkg::OP_CAPTURE);
   assign fwd_delta = req_capture_value - last_ff;
   assign wrap_delta = {1'b0, cfg.timer_period} - {1'b0, last_ff} + {1'b0, req_capture_value};
   assign delta = (req_capture_value >= last_ff) ? {1'b0, fwd_delta} : wrap_delta;

   always_comb begin
      q_cmd.is_eval = !is_capture;
      q_cmd.store = is_capture && (delta != 17'd0);
      q_cmd.delta = delta;
      q_cmd.now_ms = req_now_ms;
      last_in = last_ff;
      if (q_push && is_capture) begin
         last_in = req_capture_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= 16'd0;
      end else begin
         last_ff <= last_in;
      end
   end
endmodule

// File: sv/cfm_queue.sv
// two-entry command queue between front and back
module cfm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cfm_pkg::cmd_type din,
   output logic             full,
   input  logic             pop,
   output cfm_pkg::cmd_type dout,
   output logic             empty
);
   cfm_pkg::cmd_type mem_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;

   assign full = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign dout = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

// File: sv/cfm_back.sv
// back end: ring update, sum walk, multiply, serial divide, result word
module cfm_back #(
   parameter int RING_DEPTH = cfm_pkg::RING_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  cfm_pkg::cfg_type cfg,
   input  logic             q_empty,
   input  cfm_pkg::cmd_type q_cmd,
   output logic             q_pop,
   input  logic             rsp_pop,
   output logic             rsp_valid,
   output logic [47:0]      rsp_frequency_q16,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_pulse_total,
   output logic [3:0]       rsp_samples_held
);
   `include "capture_frequency_meter_assert.svh"

   localparam int CW = $clog2(RING_DEPTH + 1);
   localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int PW = cfm_pkg::PERIOD_W;
   localparam int FW = cfm_pkg::FREQ_W;
   localparam int SW = PW + CW;
   localparam int MW = 32 + CW;
   localparam int NW = MW + 16;
   localparam int IW = $clog2(NW + 1);
   localparam int EW = (CW > 4) ? CW : 4;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SUM = 3'd1;
   localparam logic [2:0] S_MUL = 3'd2;
   localparam logic [2:0] S_DIV = 3'd3;
   localparam logic [2:0] S_FIN = 3'd4;
   localparam logic [2:0] S_RESULT = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] widx_ff, widx_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   pulse_ff, pulse_in;
   logic          newdata_ff, newdata_in;
   logic [31:0]   last_ms_ff, last_ms_in;
   logic [1:0]    held_status_ff, held_status_in;
   logic [FW-1:0] held_freq_ff, held_freq_in;
   logic [CW-1:0] k_ff, k_in;
   logic          issue_ff, issue_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [NW-1:0] qn_ff, qn_in;
   logic [SW:0]   rem_ff, rem_in;
   logic [IW-1:0] iter_ff, iter_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0] rsp_freq_ff, rsp_freq_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [31:0]   rsp_pulse_ff, rsp_pulse_in;
   logic [3:0]    rsp_samples_ff, rsp_samples_in;

   logic          ram_we;
   logic [PW-1:0] ram_rdata;
   logic          slot_free;
   logic [1:0]    status_eff;
   logic [31:0]   idle_ms;
   logic [MW-1:0] product;
   logic [SW:0]   rem_sh;
   logic [SW:0]   sum_ext;
   logic [FW-1:0] sat_freq;
   logic [EW-1:0] count_ext;

   cfm_ram #(
      .WIDTH(PW),
      .DEPTH(RING_DEPTH)
   ) u_ring (
      .clock(clock),
      .we(ram_we),
      .waddr(widx_ff),
      .wdata(q_cmd.delta),
      .raddr(k_ff[AW-1:0]),
      .rdata(ram_rdata)
   );

   assign slot_free = !rsp_valid_ff || rsp_pop;
   assign status_eff = (held_status_ff == cfm_pkg::STATUS_DISABLED) ?
                       cfm_pkg::STATUS_IDENT : held_status_ff;
   assign idle_ms = q_cmd.now_ms - last_ms_ff;
   assign product = MW'(cfg.clock_hz) * MW'(count_ff);
   assign rem_sh = {rem_ff[SW-1:0], qn_ff[NW-1]};
   assign sum_ext = {1'b0, sum_ff};
   assign sat_freq = (|qn_ff[NW-1:FW]) ? {FW{1'b1}} : qn_ff[FW-1:0];
   assign count_ext = EW'(count_ff);

   always_comb begin
      state_in = state_ff;
      widx_in = widx_ff;
      count_in = count_ff;
      pulse_in = pulse_ff;
      newdata_in = newdata_ff;
      last_ms_in = last_ms_ff;
      held_status_in = held_status_ff;
      held_freq_in = held_freq_ff;
      k_in = k_ff;
      issue_in = issue_ff;
      sum_in = sum_ff;
      qn_in = qn_ff;
      rem_in = rem_ff;
      iter_in = iter_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_freq_in = rsp_freq_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pulse_in = rsp_pulse_ff;
      rsp_samples_in = rsp_samples_ff;
      ram_we = 1'b0;
      q_pop = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (!q_cmd.is_eval) begin
                  if (q_cmd.store) begin
                     ram_we = 1'b1;
                     widx_in = (widx_ff == AW'(RING_DEPTH - 1)) ? '0 : widx_ff + 1'b1;
                     if (count_ff != CW'(RING_DEPTH)) begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  pulse_in = pulse_ff + 32'd1;
                  newdata_in = 1'b1;
               end else begin
                  newdata_in = 1'b0;
                  state_in = S_RESULT;
                  if (!cfg.enable) begin
                     held_status_in = cfm_pkg::STATUS_DISABLED;
                     held_freq_in = '0;
                  end else if (newdata_ff) begin
                     last_ms_in = q_cmd.now_ms;
                     if (count_ff != '0) begin
                        held_status_in = status_eff;
                        k_in = '0;
                        issue_in = 1'b0;
                        sum_in = '0;
                        state_in = S_SUM;
                     end else begin
                        held_status_in = cfm_pkg::STATUS_IDENT;
                     end
                  end else if (idle_ms >= cfg.timeout) begin
                     held_freq_in = '0;
                     held_status_in = cfm_pkg::STATUS_FAULT;
                     count_in = '0;
                     widx_in = '0;
                  end else begin
                     held_status_in = status_eff;
                  end
               end
            end
         end
         S_SUM: begin
            // the ram read is issued, then its registered data is accumulated in the next cycle
            issue_in = (k_ff != count_ff);
            if (k_ff != count_ff) begin
               k_in = k_ff + 1'b1;
            end
            if (issue_ff) begin
               sum_in = sum_ff + SW'(ram_rdata);
            end
            if (k_ff == count_ff && !issue_ff) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            qn_in = {product, 16'd0};
            rem_in = '0;
            iter_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (rem_sh >= sum_ext) begin
               rem_in = rem_sh - sum_ext;
               qn_in = {qn_ff[NW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               qn_in = {qn_ff[NW-2:0], 1'b0};
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == IW'(NW - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            held_freq_in = sat_freq;
            held_status_in = (sat_freq >= FW'(cfg.min_freq)) ?
                             cfm_pkg::STATUS_OK : cfm_pkg::STATUS_FAULT;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_freq_in = held_freq_ff;
               rsp_status_in = held_status_ff;
               rsp_pulse_in = pulse_ff;
               rsp_samples_in = (count_ext > EW'(cfm_pkg::SAMPLES_MAX)) ?
                                cfm_pkg::SAMPLES_MAX : count_ext[3:0];
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         widx_ff <= '0;
         count_ff <= '0;
         pulse_ff <= 32'd0;
         newdata_ff <= 1'b0;
         last_ms_ff <= 32'd0;
         held_status_ff <= cfm_pkg::STATUS_OK;
         held_freq_ff <= '0;
         k_ff <= '0;
         issue_ff <= 1'b0;
         iter_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         widx_ff <= widx_in;
         count_ff <= count_in;
         pulse_ff <= pulse_in;
         newdata_ff <= newdata_in;
         last_ms_ff <= last_ms_in;
         held_status_ff <= held_status_in;
         held_freq_ff <= held_freq_in;
         k_ff <= k_in;
         issue_ff <= issue_in;
         iter_ff <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      qn_ff <= qn_in;
      rem_ff <= rem_in;
      rsp_freq_ff <= rsp_freq_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pulse_ff <= rsp_pulse_in;
      rsp_samples_ff <= rsp_samples_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_frequency_q16 = rsp_freq_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_pulse_total = rsp_pulse_ff;
   assign rsp_samples_held = rsp_samples_ff;

   `CFM_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CW'(RING_DEPTH))
   `CFM_ASSERT_SAME(a_walk_bound, state_ff == S_SUM, k_ff <= count_ff)
   `CFM_ASSERT_NEXT(a_result_out, state_ff == S_RESULT && slot_free, rsp_valid_ff)
   `CFM_ASSERT_SAME(a_no_pop_busy, state_ff != S_IDLE, !q_pop)
endmodule

// File: sv/capture_frequency_meter.sv
// top level of the capture frequency meter: config registers, front, queue, back
// capture word: handled in the idle state of the back after the queue; the next word may follow at once
// evaluate word with new data and samples: walks the sum, multiply, divide, finish and result
//   states, the divider giving one quotient bit per cycle; other evaluates go straight to the result state
// one word is worked at a time in the back; the queue holds two more words
// synchronous active-high reset clears control state; config returns to defaults
module capture_frequency_meter #(
   parameter int RING_DEPTH = cfm_pkg::RING_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic [0:0]                        req_opcode,
   input  logic [15:0]                       req_capture_value,
   input  logic [31:0]                       req_now_ms,
   output logic                              empty,
   input  logic                              pop,
   output logic [47:0]                       rsp_frequency_q16,
   output logic [1:0]                        rsp_status,
   output logic [31:0]                       rsp_pulse_total,
   output logic [3:0]                        rsp_samples_held,
   input  logic                              csr_we,
   input  logic [cfm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cfm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   cfm_pkg::cfg_type cfg_ff;
   cfm_pkg::cfg_type cfg_in;
   cfm_pkg::cmd_type f_cmd;
   cfm_pkg::cmd_type q_cmd;
   logic             f_push;
   logic             q_full;
   logic             q_empty;
   logic             q_pop;
   logic             rsp_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            cfm_pkg::CSR_CHANNEL_ENABLE: cfg_in.enable = csr_wdata[0];
            cfm_pkg::CSR_TIMER_PERIOD:   cfg_in.timer_period = csr_wdata[15:0];
            cfm_pkg::CSR_TIMER_CLOCK_HZ: cfg_in.clock_hz = csr_wdata;
            cfm_pkg::CSR_MIN_FREQ_Q16:   cfg_in.min_freq = csr_wdata;
            cfm_pkg::CSR_TIMEOUT_MS:     cfg_in.timeout = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable <= 1'b0;
         cfg_ff.timer_period <= cfm_pkg::TIMER_PERIOD_RESET;
         cfg_ff.clock_hz <= 32'd0;
         cfg_ff.min_freq <= 32'd0;
         cfg_ff.timeout <= cfm_pkg::TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cfm_front u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .push(push),
      .req_opcode(req_opcode),
      .req_capture_value(req_capture_value),
      .req_now_ms(req_now_ms),
      .q_full(q_full),
      .q_push(f_push),
      .q_cmd(f_cmd)
   );

   cfm_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(f_push),
      .din(f_cmd),
      .full(q_full),
      .pop(q_pop),
      .dout(q_cmd),
      .empty(q_empty)
   );

   cfm_back #(
      .RING_DEPTH(RING_DEPTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .q_empty(q_empty),
      .q_cmd(q_cmd),
      .q_pop(q_pop),
      .rsp_pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_frequency_q16(rsp_frequency_q16),
      .rsp_status(rsp_status),
      .rsp_pulse_total(rsp_pulse_total),
      .rsp_samples_held(rsp_samples_held)
   );

   assign full = q_full;
   assign empty = !rsp_valid;
endmodule

// File: tb/tb_capture_frequency_meter.sv
// self-checking testbench for the capture frequency meter, with its frequency predictor
`timescale 1ns / 100ps

class meter_tracker;
   localparam int DEPTH = cfm_pkg::RING_DEPTH_DEFAULT;

   typedef struct packed {
      logic [47:0] freq;
      logic [1:0]  status;
      logic [31:0] pulses;
      logic [3:0]  samples;
   } reading_type;

   reading_type pending_readings[$];
   int errors;

   bit          enable;
   bit [15:0]   timer_period;
   bit [31:0]   clock_hz;
   bit [31:0]   min_freq;
   bit [31:0]   timeout;

   bit [15:0]   last_capture;
   bit [16:0]   period_ring[DEPTH];
   int unsigned ring_wr;
   int unsigned sample_cnt;
   bit [31:0]   pulses;
   bit          fresh;
   bit [31:0]   last_update;
   bit [1:0]    status;
   bit [47:0]   freq;

   function new();
      errors = 0;
      enable = 1'b0;
      timer_period = cfm_pkg::TIMER_PERIOD_RESET;
      clock_hz = '0;
      min_freq = '0;
      timeout = cfm_pkg::TIMEOUT_RESET;
      last_capture = '0;
      ring_wr = 0;
      sample_cnt = 0;
      pulses = '0;
      fresh = 1'b0;
      last_update = '0;
      status = cfm_pkg::STATUS_OK;
      freq = '0;
   endfunction

   function void set_reg(logic [cfm_pkg::CSR_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
         cfm_pkg::CSR_CHANNEL_ENABLE: enable = val[0];
         cfm_pkg::CSR_TIMER_PERIOD:   timer_period = val[15:0];
         cfm_pkg::CSR_TIMER_CLOCK_HZ: clock_hz = val;
         cfm_pkg::CSR_MIN_FREQ_Q16:   min_freq = val;
         cfm_pkg::CSR_TIMEOUT_MS:     timeout = val;
         default: ;
      endcase
   endfunction

   function void take_capture(logic [15:0] cur);
      bit [16:0] gap;
      if (cur >= last_capture) begin
         gap = {1'b0, cur - last_capture};
      end else begin
         gap = {1'b0, timer_period} - {1'b0, last_capture} + {1'b0, cur};
      end
      if (gap != 0) begin
         period_ring[ring_wr] = gap;
         ring_wr = (ring_wr + 1) % DEPTH;
         if (sample_cnt < DEPTH) sample_cnt++;
      end
      pulses++;
      last_capture = cur;
      fresh = 1'b1;
   endfunction

   function reading_type evaluate(logic [31:0] now);
      reading_type r;
      bit [63:0] total;
      bit [63:0] num;
      bit [63:0] q;
      bit [31:0] elapsed;
      elapsed = now - last_update;
      if (!enable) begin
         status = cfm_pkg::STATUS_DISABLED;
         freq = '0;
      end else begin
         if (status == cfm_pkg::STATUS_DISABLED) status = cfm_pkg::STATUS_IDENT;
         if (fresh) begin
            if (sample_cnt > 0) begin
               total = '0;
               for (int k = 0; k < sample_cnt; k++) total += 64'(period_ring[k]);
               num = {32'd0, clock_hz} * 64'(sample_cnt);
               num = num << 16;
               q = num / total;
               freq = (q > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : q[47:0];
               status = (freq >= {16'd0, min_freq}) ?
                        cfm_pkg::STATUS_OK : cfm_pkg::STATUS_FAULT;
            end else begin
               status = cfm_pkg::STATUS_IDENT;
            end
            last_update = now;
         end else if (elapsed >= timeout) begin
            freq = '0;
            status = cfm_pkg::STATUS_FAULT;
            sample_cnt = 0;
            ring_wr = 0;
         end
      end
      fresh = 1'b0;
      r.freq = freq;
      r.status = status;
      r.pulses = pulses;
      r.samples = (sample_cnt > 15) ? cfm_pkg::SAMPLES_MAX : 4'(sample_cnt);
      return r;
   endfunction

   function void note_word(logic [0:0] op, logic [15:0] cap, logic [31:0] now);
      if (op == cfm_pkg::OP_CAPTURE) take_capture(cap);
      else pending_readings.push_back(evaluate(now));
   endfunction

   function void compare_field(string name, logic [47:0] want, logic [47:0] got);
      if (got !== want) begin
         $error("%s expected %0h got %0h", name, want, got);
         errors++;
      end
   endfunction

   function void check_reading(logic [47:0] f, logic [1:0] s, logic [31:0] p, logic [3:0] n);
      reading_type want;
      if (pending_readings.size() == 0) begin
         $error("result word with no evaluate pending: frequency_q16 %0h status %0d", f, s);
         errors++;
      end else begin
         want = pending_readings.pop_front();
         compare_field("frequency_q16", want.freq, f);
         compare_field("status", 48'(want.status), 48'(s));
         compare_field("pulse_total", 48'(want.pulses), 48'(p));
         compare_field("samples_held", 48'(want.samples), 48'(n));
      end
   endfunction
endclass

module tb_capture_frequency_meter;
   localparam int SETTLE_CYCLES = 120;
   localparam int HOLD_CYCLES = 400;
   localparam longint LIMIT_NS = 36_000_000;

   logic                           clock;
   logic                           reset;
   logic                           push;
   logic                           full;
   logic [0:0]                     req_opcode;
   logic [15:0]                    req_capture_value;
   logic [31:0]                    req_now_ms;
   logic                           empty;
   logic                           pop;
   logic [47:0]                    rsp_frequency_q16;
   logic [1:0]                     rsp_status;
   logic [31:0]                    rsp_pulse_total;
   logic [3:0]                     rsp_samples_held;
   logic                           csr_we;
   logic [cfm_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [cfm_pkg::CSR_DATA_W-1:0] csr_wdata;

   meter_tracker tracker;
   int           burst_left = 0;
   bit           steady = 1'b0;
   bit           hold_request = 1'b0;
   bit [31:0]    ms_clock = '0;
   logic [15:0]  last_sent_capture = '0;
   int unsigned  tick_mod = 65536;

   capture_frequency_meter dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_opcode(req_opcode),
      .req_capture_value(req_capture_value),
      .req_now_ms(req_now_ms),
      .empty(empty),
      .pop(pop),
      .rsp_frequency_q16(rsp_frequency_q16),
      .rsp_status(rsp_status),
      .rsp_pulse_total(rsp_pulse_total),
      .rsp_samples_held(rsp_samples_held),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin : watchdog
      #(LIMIT_NS);
      $display("tb_capture_frequency_meter failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) tracker.note_word(req_opcode, req_capture_value, req_now_ms);
         if (pop && !empty) begin
            tracker.check_reading(rsp_frequency_q16, rsp_status, rsp_pulse_total,
                                  rsp_samples_held);
         end
      end
   end

   initial begin : receiver
      int mode;
      int span;
      pop <= 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 200);
         for (int k = 0; k < span; k++) begin
            @(posedge clock);
            if (hold_request) begin
               hold_request = 1'b0;
               pop <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
            end
            case (mode)
               0: pop <= 1'b1;
               1: pop <= 1'($urandom_range(0, 1));
               2: pop <= ($urandom_range(0, 7) == 0);
               default: pop <= 1'(k >> 2);
            endcase
         end
      end
   end

   task automatic send_word(logic [0:0] op, logic [15:0] cap, logic [31:0] now);
      if (burst_left == 0 && !steady) begin
         push <= 1'b0;
         if ($urandom_range(0, 7) == 0) repeat ($urandom_range(10, 120)) @(posedge clock);
         else repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      if (burst_left > 0) burst_left--;
      push <= 1'b1;
      req_opcode <= op;
      req_capture_value <= cap;
      req_now_ms <= now;
      do @(posedge clock); while (full);
   endtask

   task automatic settle();
      push <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (tracker.pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [cfm_pkg::CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      tracker.set_reg(idx, val);
   endtask

   task automatic send_random(int count, bit with_hold);
      logic [15:0] cap;
      int unsigned advance;
      int r;
      for (int i = 0; i < count; i++) begin
         if (with_hold && i == 10) begin
            hold_request = 1'b1;
            steady = 1'b1;
         end
         if (with_hold && i == 80) steady = 1'b0;
         if ($urandom_range(0, 99) < 65) begin
            if ($urandom_range(0, 4) == 0) begin
               cap = 16'($urandom_range(0, 65535));
            end else begin
               advance = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4000);
               cap = 16'((32'(last_sent_capture) + advance) % tick_mod);
            end
            last_sent_capture = cap;
            send_word(cfm_pkg::OP_CAPTURE, cap, $urandom);
         end else begin
            r = $urandom_range(0, 19);
            if (r == 0) ms_clock = $urandom;
            else if (r < 4) ms_clock += $urandom_range(1000, 6000);
            else ms_clock += $urandom_range(0, 400);
            send_word(cfm_pkg::OP_EVALUATE, 16'($urandom_range(0, 65535)), ms_clock);
         end
      end
   endtask

   initial begin : stimulus
      bit [31:0] en;
      bit [31:0] per;
      bit [31:0] clk_hz;
      bit [31:0] minf;
      bit [31:0] tmo;
      tracker = new();
      reset <= 1'b1;
      push <= 1'b0;
      req_opcode <= cfm_pkg::OP_CAPTURE;
      req_capture_value <= '0;
      req_now_ms <= '0;
      csr_we <= 1'b0;
      csr_index <= cfm_pkg::CSR_CHANNEL_ENABLE;
      csr_wdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // held status from reset, timeout, zero difference, identifying
      write_reg(cfm_pkg::CSR_CHANNEL_ENABLE, 32'd1);
      send_word(cfm_pkg::OP_EVALUATE, 16'h0000, 32'd10);
      send_word(cfm_pkg::OP_EVALUATE, 16'h0000, 32'd2000);
      send_word(cfm_pkg::OP_CAPTURE, 16'h0000, 32'd0);
      send_word(cfm_pkg::OP_EVALUATE, 16'h0000, 32'd2001);
      send_word(cfm_pkg::OP_CAPTURE, 16'hFFFF, 32'd0);
      send_word(cfm_pkg::OP_CAPTURE, 16'h0000, 32'd0);
      send_word(cfm_pkg::OP_CAPTURE, 16'h0001, 32'd0);
      send_word(cfm_pkg::OP_EVALUATE, 16'h0000, 32'd2002);
      settle();

      // extreme clock and limits, wide wrapped difference, timeout at full span
      write_reg(cfm_pkg::CSR_TIMER_CLOCK_HZ, 32'hFFFF_FFFF);
      write_reg(cfm_pkg::CSR_MIN_FREQ_Q16, 32'hFFFF_FFFF);
      write_reg(cfm_pkg::CSR_TIMEOUT_MS, 32'hFFFF_FFFF);
      write_reg(cfm_pkg::CSR_TIMER_PERIOD, 32'hFFFF_0000);
      send_word(cfm_pkg::OP_CAPTURE, 16'h8000, 32'd0);
      send_word(cfm_pkg::OP_CAPTURE, 16'h0010, 32'd0);
      send_word(cfm_pkg::OP_EVALUATE, 16'h0000, 32'd5);
      send_word(cfm_pkg::OP_EVALUATE, 16'h0000, 32'd4);
      send_word(cfm_pkg::OP_CAPTURE, 16'h0011, 32'd0);
      send_word(cfm_pkg::OP_CAPTURE, 16'h0012, 32'd0);
      send_word(cfm_pkg::OP_EVALUATE, 16'h0000, 32'd6);
      send_word(cfm_pkg::OP_EVALUATE, 16'h0000, 32'd7);
      settle();

      write_reg(cfm_pkg::CSR_TIMER_CLOCK_HZ, 32'd1);
      send_word(cfm_pkg::OP_CAPTURE, 16'h0013, 32'd0);
      send_word(cfm_pkg::OP_EVALUATE, 16'h0000, 32'd8);
      settle();

      // disabled channel, then back to identifying
      write_reg(cfm_pkg::CSR_CHANNEL_ENABLE, 32'hFFFF_FFFE);
      send_word(cfm_pkg::OP_CAPTURE, 16'h0020, 32'd0);
      send_word(cfm_pkg::OP_EVALUATE, 16'h0000, 32'd9);
      settle();
      write_reg(cfm_pkg::CSR_CHANNEL_ENABLE, 32'd1);
      send_word(cfm_pkg::OP_EVALUATE, 16'h0000, 32'd10);
      send_word(cfm_pkg::OP_CAPTURE, 16'h0030, 32'd0);
      send_word(cfm_pkg::OP_EVALUATE, 16'h0000, 32'd11);
      settle();

      ms_clock = 32'd100;
      last_sent_capture = 16'h0030;
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin
               en = 1; per = 32'hFFFF; clk_hz = 1_000_000;
               minf = $urandom_range(0, 40_000_000); tmo = 2000;
            end
            1: begin
               en = 1; per = $urandom_range(50, 2000); clk_hz = $urandom;
               minf = $urandom; tmo = $urandom_range(0, 3000);
            end
            2: begin
               en = 0; per = $urandom_range(0, 65535); clk_hz = $urandom;
               minf = $urandom; tmo = $urandom;
            end
            3: begin
               en = 1; per = 0; clk_hz = 32'hFFFF_FFFF; minf = 0; tmo = 0;
            end
            4: begin
               en = 1; per = 32'hFFFF; clk_hz = 16_000_000;
               minf = 32'hFFFF_FFFF; tmo = 32'hFFFF_FFFF;
            end
            5: begin
               en = 1; per = $urandom_range(1000, 65535); clk_hz = 0; minf = 0; tmo = 2000;
            end
            default: begin
               en = ($urandom_range(0, 3) != 0); per = $urandom_range(0, 65535);
               clk_hz = $urandom; minf = $urandom; tmo = $urandom_range(0, 5000);
               ms_clock = 32'hFFFF_F000;
            end
         endcase
         write_reg(cfm_pkg::CSR_CHANNEL_ENABLE, en);
         write_reg(cfm_pkg::CSR_TIMER_PERIOD, per);
         write_reg(cfm_pkg::CSR_TIMER_CLOCK_HZ, clk_hz);
         write_reg(cfm_pkg::CSR_MIN_FREQ_Q16, minf);
         write_reg(cfm_pkg::CSR_TIMEOUT_MS, tmo);
         tick_mod = (per[15:0] == 16'd0) ? 65536 : 32'(per[15:0]) + 1;
         send_random(110, p == 4);
         settle();
      end

      if (tracker.errors == 0) $display("tb_capture_frequency_meter passed");
      else $display("tb_capture_frequency_meter failed");
      $finish;
   end
endmodule
